// File: hdl/single_wire_uart_transceiver_top_defines.svh
// ----------------------------------------------------------------------------
// Single-wire UART transceiver assertion macros
// Shared assertion helpers, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_UART_TRANSCEIVER_TOP_DEFINES_SVH
`define SINGLE_WIRE_UART_TRANSCEIVER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWUT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWUT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/swut_pkg.sv
// ----------------------------------------------------------------------------
// Single-wire UART transceiver package
// Types and fixed constants shared by the step logic and the top level.
// ----------------------------------------------------------------------------
package swut_pkg;

  localparam int FRAME_BITS = 10;
  localparam int TICK_W     = 16;
  localparam int CNT_W      = 4;
  localparam int RX_SHIFT_W = FRAME_BITS - 1;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd1;

  localparam logic [CFG_W-1:0] BIT_PERIOD_RST   = 16'd1667;
  localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RST = 16'd500;

  localparam logic [FRAME_BITS-1:0] TX_SHIFT_IDLE = {FRAME_BITS{1'b1}};

  typedef enum logic [1:0] {
    TXP_IDLE  = 2'd0,
    TXP_LEAD  = 2'd1,
    TXP_SHIFT = 2'd2
  } tx_phase_t;

  typedef enum logic [1:0] {
    RXP_HUNT = 2'd0,
    RXP_HALF = 2'd1,
    RXP_DATA = 2'd2
  } rx_phase_t;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_BYTE      = 2'd1,
    EV_FRAME_ERR = 2'd2,
    EV_TIMEOUT   = 2'd3
  } rx_event_t;

  typedef struct packed {
    logic [TICK_W-1:0]     tick_count;
    tx_phase_t             tx_phase;
    logic [FRAME_BITS-1:0] tx_shift;
    logic [CNT_W-1:0]      tx_bits_left;
    rx_phase_t             rx_phase;
    logic [RX_SHIFT_W-1:0] rx_shift;
    logic [CNT_W-1:0]      rx_bits_left;
    logic [TICK_W-1:0]     idle_periods;
  } state_t;

  typedef struct packed {
    logic      line_out;
    logic      line_drive;
    logic      send_ready;
    rx_event_t rx_event;
    logic [7:0] rx_data;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] bit_period;
    logic [CFG_W-1:0] idle_timeout;
  } cfg_t;

endpackage

// File: hdl/single_wire_uart_transceiver_top.sv
// ----------------------------------------------------------------------------
// Single-wire UART transceiver top level
// Half-duplex 8N1 port on one shared line, one sample transfer per cycle while out_ready allows.
// ----------------------------------------------------------------------------
// Channel | Handshake             | Payload
// in      | in_valid / in_ready   | in_line_in, in_send_req, in_send_byte
// out     | out_valid / out_ready | out_line_out, out_line_drive, out_send_ready,
//         |                       | out_rx_event, out_rx_data
// cfg     | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// On each input transfer the step logic updates the shared bit timer and both
// direction sequencers, and the result lands in the output register.
// One transfer per cycle is sustained while out_ready stays high.
// The output register stalls only the input side; the state moves only on a transfer.
// Synchronous reset restores the register defaults and an idle transmitter
// and hunting receiver.
// ----------------------------------------------------------------------------
module single_wire_uart_transceiver_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_line_in,
  input  logic                              in_send_req,
  input  logic [7:0]                        in_send_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_line_out,
  output logic                              out_line_drive,
  output logic                              out_send_ready,
  output logic [1:0]                        out_rx_event,
  output logic [7:0]                        out_rx_data,
  input  logic                              cfg_we,
  input  logic [swut_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [swut_pkg::CFG_W-1:0]        cfg_wdata
);
  import swut_pkg::*;
  `include "single_wire_uart_transceiver_top_defines.svh"

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res;
  result_t res_r;
  logic    out_valid_r;
  logic    in_xfer;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  swut_step u_step (
    .cfg       (cfg_r),
    .cur       (state_r),
    .line_in   (in_line_in),
    .send_req  (in_send_req),
    .send_byte (in_send_byte),
    .nxt       (state_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_period   <= BIT_PERIOD_RST;
      cfg_r.idle_timeout <= IDLE_TIMEOUT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BIT_PERIOD) begin
        cfg_r.bit_period <= cfg_wdata;
      end else if (cfg_index == CFG_IDLE_TIMEOUT) begin
        cfg_r.idle_timeout <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.tick_count   <= '0;
      state_r.tx_phase     <= TXP_IDLE;
      state_r.tx_shift     <= TX_SHIFT_IDLE;
      state_r.tx_bits_left <= '0;
      state_r.rx_phase     <= RXP_HUNT;
      state_r.rx_shift     <= '0;
      state_r.rx_bits_left <= '0;
      state_r.idle_periods <= '0;
      out_valid_r          <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_out   = res_r.line_out;
  assign out_line_drive = res_r.line_drive;
  assign out_send_ready = res_r.send_ready;
  assign out_rx_event   = res_r.rx_event;
  assign out_rx_data    = res_r.rx_data;

  `SWUT_ASSERT_SAME(a_tx_busy_rx_hunt, state_r.tx_phase != TXP_IDLE,
    state_r.rx_phase == RXP_HUNT, "receiver left hunting during transmission")
  `SWUT_ASSERT_NEXT(a_send_starts_lead,
    in_xfer && in_send_req && state_r.tx_phase == TXP_IDLE && state_r.rx_phase == RXP_HUNT,
    state_r.tx_phase == TXP_LEAD && out_line_drive && out_send_ready,
    "accepted send did not start the lead period")
  `SWUT_ASSERT_NEXT(a_event_not_driving, in_xfer && res.rx_event != EV_NONE,
    !out_line_drive, "receive event reported while driving the line")
  `SWUT_ASSERT_SAME(a_data_only_on_byte, out_valid_r && out_rx_event != EV_BYTE,
    out_rx_data == 8'd0, "received data nonzero without a byte event")

endmodule

// File: hdl/swut_step.sv
// ----------------------------------------------------------------------------
// Single-wire UART transceiver step logic
// Next state and result for one line sample and send request.
// ----------------------------------------------------------------------------
module swut_step (
  input  swut_pkg::cfg_t    cfg,
  input  swut_pkg::state_t  cur,
  input  logic              line_in,
  input  logic              send_req,
  input  logic [7:0]        send_byte,
  output swut_pkg::state_t  nxt,
  output swut_pkg::result_t res
);
  import swut_pkg::*;

  logic [TICK_W-1:0] bp;
  logic [TICK_W-1:0] half;
  logic [TICK_W-1:0] lim;
  logic [TICK_W-1:0] period_lim;
  logic [TICK_W-1:0] tick_inc;
  logic [TICK_W-1:0] tick_adv;
  logic [TICK_W-1:0] idle_inc;
  logic [CNT_W-1:0]  tx_bl_dec;
  logic [CNT_W-1:0]  rx_bl_dec;
  logic [RX_SHIFT_W-1:0] rx_shift_new;
  logic              done;
  logic              ready;

  assign bp   = (cfg.bit_period == '0) ? TICK_W'(1) : cfg.bit_period;
  assign half = (cfg.bit_period[CFG_W-1:1] == '0) ? TICK_W'(1)
                                                  : {1'b0, cfg.bit_period[CFG_W-1:1]};
  assign lim  = (cfg.idle_timeout == '0) ? TICK_W'(1) : cfg.idle_timeout;

  // Only the receiver's half wait uses the half period; every other count is a full bit.
  assign period_lim = (cur.tx_phase == TXP_IDLE && cur.rx_phase == RXP_HALF) ? half : bp;

  assign tick_inc = cur.tick_count + TICK_W'(1);
  assign done     = (tick_inc >= period_lim) || (tick_inc == '0);
  assign tick_adv = done ? '0 : tick_inc;

  assign idle_inc     = cur.idle_periods + TICK_W'(1);
  assign tx_bl_dec    = cur.tx_bits_left - CNT_W'(1);
  assign rx_bl_dec    = cur.rx_bits_left - CNT_W'(1);
  assign rx_shift_new = {line_in, cur.rx_shift[RX_SHIFT_W-1:1]};

  assign ready = (cur.tx_phase == TXP_IDLE) && (cur.rx_phase == RXP_HUNT);

  always_comb begin
    nxt            = cur;
    res.rx_event   = EV_NONE;
    res.rx_data    = '0;
    res.send_ready = ready;
    if (ready && send_req) begin
      nxt.tx_phase     = TXP_LEAD;
      nxt.tx_shift     = {1'b1, send_byte, 1'b0};
      nxt.tx_bits_left = '0;
      nxt.tick_count   = '0;
      nxt.idle_periods = '0;
    end else begin
      unique case (cur.tx_phase)
        TXP_LEAD: begin
          nxt.tick_count = tick_adv;
          if (done) begin
            nxt.tx_phase     = TXP_SHIFT;
            nxt.tx_bits_left = CNT_W'(FRAME_BITS);
          end
        end
        TXP_SHIFT: begin
          nxt.tick_count = tick_adv;
          if (done) begin
            nxt.tx_shift     = {1'b1, cur.tx_shift[FRAME_BITS-1:1]};
            nxt.tx_bits_left = tx_bl_dec;
            if (tx_bl_dec == '0) begin
              nxt.tx_phase   = TXP_IDLE;
              nxt.tx_shift   = TX_SHIFT_IDLE;
              nxt.tick_count = '0;
            end
          end
        end
        TXP_IDLE: begin
          unique case (cur.rx_phase)
            RXP_HUNT: begin
              if (!line_in) begin
                nxt.rx_phase     = RXP_HALF;
                nxt.tick_count   = '0;
                nxt.idle_periods = '0;
              end else begin
                nxt.tick_count = tick_adv;
                if (done) begin
                  if (idle_inc >= lim) begin
                    res.rx_event     = EV_TIMEOUT;
                    nxt.idle_periods = '0;
                  end else begin
                    nxt.idle_periods = idle_inc;
                  end
                end
              end
            end
            RXP_HALF: begin
              nxt.tick_count = tick_adv;
              if (done) begin
                nxt.rx_phase     = RXP_DATA;
                nxt.rx_shift     = '0;
                nxt.rx_bits_left = CNT_W'(FRAME_BITS - 1);
              end
            end
            RXP_DATA: begin
              nxt.tick_count = tick_adv;
              if (done) begin
                nxt.rx_shift     = rx_shift_new;
                nxt.rx_bits_left = rx_bl_dec;
                if (rx_bl_dec == '0) begin
                  // The ninth sample is the stop bit; low means a framing error.
                  if (rx_shift_new[RX_SHIFT_W-1]) begin
                    res.rx_event = EV_BYTE;
                    res.rx_data  = rx_shift_new[7:0];
                  end else begin
                    res.rx_event = EV_FRAME_ERR;
                  end
                  nxt.rx_phase     = RXP_HUNT;
                  nxt.tick_count   = '0;
                  nxt.idle_periods = '0;
                end
              end
            end
            default: nxt.rx_phase = RXP_HUNT;
          endcase
        end
        default: nxt.tx_phase = TXP_IDLE;
      endcase
    end

    // Line outputs follow the state after the step.
    unique case (nxt.tx_phase)
      TXP_SHIFT: begin
        res.line_out   = nxt.tx_shift[0];
        res.line_drive = 1'b1;
      end
      TXP_LEAD: begin
        res.line_out   = 1'b1;
        res.line_drive = 1'b1;
      end
      default: begin
        res.line_out   = 1'b1;
        res.line_drive = 1'b0;
      end
    endcase
  end

endmodule

// File: sim/tb_single_wire_uart_transceiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-wire UART transceiver testbench
// Streams line samples and send requests into the transceiver and predicts
// each result transfer cycle by cycle. It covers receive frames, framing
// errors, idle timeouts, sends and collisions across several register
// settings, with random gaps on the input side and stalls on the output side.
// ----------------------------------------------------------------------------
module tb_single_wire_uart_transceiver_top;
  import swut_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int REPORT_CAP = 100;
  localparam int RANDOM_CAP = 30000;

  class line_scoreboard;
    logic [CFG_W-1:0]      bit_period;
    logic [CFG_W-1:0]      idle_timeout;
    logic [TICK_W-1:0]     tick;
    tx_phase_t             tx_ph;
    logic [FRAME_BITS-1:0] tx_frame;
    logic [CNT_W-1:0]      tx_left;
    rx_phase_t             rx_ph;
    logic [RX_SHIFT_W-1:0] rx_bits;
    logic [CNT_W-1:0]      rx_left;
    logic [TICK_W-1:0]     idle_cnt;
    result_t               pending_results[$];
    int                    errors;
    int                    bytes_seen;

    function new();
      bit_period   = BIT_PERIOD_RST;
      idle_timeout = IDLE_TIMEOUT_RST;
      tick         = '0;
      tx_ph        = TXP_IDLE;
      tx_frame     = TX_SHIFT_IDLE;
      tx_left      = '0;
      rx_ph        = RXP_HUNT;
      rx_bits      = '0;
      rx_left      = '0;
      idle_cnt     = '0;
      errors       = 0;
      bytes_seen   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_BIT_PERIOD) begin
        bit_period = val;
      end else if (idx == CFG_IDLE_TIMEOUT) begin
        idle_timeout = val;
      end
    endfunction

    // The bit timer is shared by both directions; a period ends once the
    // count reaches or passes the limit, or wraps.
    function bit bump_tick(int unsigned limit);
      logic [TICK_W-1:0] nt;
      nt = tick + 1'b1;
      if (nt >= limit || nt == '0) begin
        tick = '0;
        return 1'b1;
      end
      tick = nt;
      return 1'b0;
    endfunction

    function void note_sample(logic line, logic req, logic [7:0] sbyte);
      result_t     r;
      logic        ready;
      rx_event_t   ev;
      logic [7:0]  data;
      int unsigned bp;
      int unsigned half;
      int unsigned lim;
      ready = (tx_ph == TXP_IDLE) && (rx_ph == RXP_HUNT);
      ev    = EV_NONE;
      data  = '0;
      bp    = (bit_period != 0) ? bit_period : 1;
      half  = ((bit_period >> 1) != 0) ? (bit_period >> 1) : 1;
      lim   = (idle_timeout != 0) ? idle_timeout : 1;
      if (ready && req) begin
        // A send wins over a start edge seen in the same cycle.
        tx_ph    = TXP_LEAD;
        tx_frame = {1'b1, sbyte, 1'b0};
        tx_left  = '0;
        tick     = '0;
        idle_cnt = '0;
      end else if (tx_ph == TXP_LEAD) begin
        if (bump_tick(bp)) begin
          tx_ph   = TXP_SHIFT;
          tx_left = CNT_W'(FRAME_BITS);
        end
      end else if (tx_ph == TXP_SHIFT) begin
        if (bump_tick(bp)) begin
          tx_frame = {1'b1, tx_frame[FRAME_BITS-1:1]};
          tx_left  = tx_left - 1'b1;
          if (tx_left == '0) begin
            tx_ph    = TXP_IDLE;
            tx_frame = TX_SHIFT_IDLE;
            tick     = '0;
          end
        end
      end else if (rx_ph == RXP_HUNT) begin
        if (!line) begin
          rx_ph    = RXP_HALF;
          tick     = '0;
          idle_cnt = '0;
        end else if (bump_tick(bp)) begin
          idle_cnt = idle_cnt + 1'b1;
          if (idle_cnt >= lim) begin
            ev       = EV_TIMEOUT;
            idle_cnt = '0;
          end
        end
      end else if (rx_ph == RXP_HALF) begin
        if (bump_tick(half)) begin
          rx_ph   = RXP_DATA;
          rx_bits = '0;
          rx_left = CNT_W'(FRAME_BITS - 1);
        end
      end else begin
        if (bump_tick(bp)) begin
          rx_bits = {line, rx_bits[RX_SHIFT_W-1:1]};
          rx_left = rx_left - 1'b1;
          if (rx_left == '0) begin
            if (rx_bits[RX_SHIFT_W-1]) begin
              ev   = EV_BYTE;
              data = rx_bits[7:0];
              bytes_seen++;
            end else begin
              ev = EV_FRAME_ERR;
            end
            rx_ph    = RXP_HUNT;
            tick     = '0;
            idle_cnt = '0;
          end
        end
      end
      r.send_ready = ready;
      r.rx_event   = ev;
      r.rx_data    = data;
      case (tx_ph)
        TXP_SHIFT: begin
          r.line_out   = tx_frame[0];
          r.line_drive = 1'b1;
        end
        TXP_LEAD: begin
          r.line_out   = 1'b1;
          r.line_drive = 1'b1;
        end
        default: begin
          r.line_out   = 1'b1;
          r.line_drive = 1'b0;
        end
      endcase
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      if (errors < REPORT_CAP) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result transfer with nothing pending (event %0d data %h)",
                         got.rx_event, got.rx_data));
        return;
      end
      want = pending_results.pop_front();
      if (got.line_out !== want.line_out)
        report($sformatf("line_out %b, want %b", got.line_out, want.line_out));
      if (got.line_drive !== want.line_drive)
        report($sformatf("line_drive %b, want %b", got.line_drive, want.line_drive));
      if (got.send_ready !== want.send_ready)
        report($sformatf("send_ready %b, want %b", got.send_ready, want.send_ready));
      if (got.rx_event !== want.rx_event)
        report($sformatf("rx_event %0d, want %0d", got.rx_event, want.rx_event));
      if (got.rx_data !== want.rx_data)
        report($sformatf("rx_data %h, want %h", got.rx_data, want.rx_data));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_line_in;
  logic                 in_send_req;
  logic [7:0]           in_send_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_line_out;
  logic                 out_line_drive;
  logic                 out_send_ready;
  logic [1:0]           out_rx_event;
  logic [7:0]           out_rx_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  line_scoreboard sb = new();
  int burst_left = 0;
  int items_sent = 0;
  int cur_period = BIT_PERIOD_RST;

  single_wire_uart_transceiver_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_line_in     (in_line_in),
    .in_send_req    (in_send_req),
    .in_send_byte   (in_send_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_line_out   (out_line_out),
    .out_line_drive (out_line_drive),
    .out_send_ready (out_send_ready),
    .out_rx_event   (out_rx_event),
    .out_rx_data    (out_rx_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.line_out   = out_line_out;
      got.line_drive = out_line_drive;
      got.send_ready = out_send_ready;
      got.rx_event   = rx_event_t'(out_rx_event);
      got.rx_data    = out_rx_data;
      sb.check_result(got);
    end
  end

  // Output stalls: mostly short ready stretches broken by brief stalls, with
  // occasional long stretches of no stall at all.
  initial begin
    int   n;
    logic level;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      case ($urandom_range(0, 9))
        0, 1: begin
          level = 1'b1;
          n     = $urandom_range(100, 400);
        end
        2, 3, 4, 5, 6: begin
          level = 1'b1;
          n     = $urandom_range(1, 30);
        end
        default: begin
          level = 1'b0;
          n     = $urandom_range(1, 6);
        end
      endcase
      repeat (n) begin
        @(negedge clk);
        out_ready <= level;
      end
    end
  end

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic drive_sample(logic line, logic req, logic [7:0] sbyte);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                               : $urandom_range(1, 48);
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_line_in   <= line;
    in_send_req  <= req;
    in_send_byte <= sbyte;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(line, req, sbyte);
    items_sent++;
  endtask

  // req_pm is the chance per sample, in thousandths, of a send request.
  task automatic drive_level(logic level, int n, int req_pm);
    repeat (n) drive_sample(level, $urandom_range(0, 999) < req_pm, 8'($urandom));
  endtask

  task automatic drive_noise(int n, int maxrun);
    int run;
    while (n > 0) begin
      run = $urandom_range(1, (maxrun < 1) ? 1 : maxrun);
      if (run > n) run = n;
      drive_level(1'($urandom_range(0, 1)), run, 3);
      n -= run;
    end
  endtask

  // Drives bits first_bit..last_bit of a start/data/stop frame on the line.
  task automatic drive_frame(logic [7:0] data, logic stop, int per, int lead,
                             int first_bit, int last_bit);
    logic [FRAME_BITS-1:0] frame;
    int                    i;
    frame = {stop, data, 1'b0};
    drive_level(1'b1, lead, 2);
    for (i = first_bit; i <= last_bit; i++) drive_level(frame[i], per, 2);
  endtask

  task automatic wait_drained();
    idle_cycles(1);
    while (sb.pending_results.size() != 0) @(posedge clk);
    idle_cycles(2);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    if (idx == CFG_BIT_PERIOD) cur_period = (val != 0) ? val : 1;
  endtask

  task automatic set_config(logic [CFG_W-1:0] period, logic [CFG_W-1:0] timeout);
    write_reg(CFG_BIT_PERIOD, period);
    write_reg(CFG_IDLE_TIMEOUT, timeout);
  endtask

  // Mostly well-formed frames with random bytes; the rest are framing errors,
  // cut-off frames, sends, noise and long idle stretches. Halfway through,
  // the sender holds off until every pending result has come back.
  task automatic run_random(int target, int min_bytes);
    int first_item;
    int first_bytes;
    int per;
    int pick;
    bit paused;
    first_item  = items_sent;
    first_bytes = sb.bytes_seen;
    paused      = 1'b0;
    while ((items_sent - first_item < target || sb.bytes_seen - first_bytes < min_bytes)
           && items_sent - first_item < RANDOM_CAP) begin
      if (!paused && items_sent - first_item >= target / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      per = cur_period;
      if ($urandom_range(0, 4) == 0) per = per + int'($urandom_range(0, 2)) - 1;
      if (per < 1) per = 1;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        drive_frame(8'($urandom), 1'b1, per, $urandom_range(0, 2 * per), 0, FRAME_BITS - 1);
      end else if (pick < 60) begin
        drive_frame(8'($urandom), 1'b0, per, $urandom_range(0, 2 * per), 0, FRAME_BITS - 1);
      end else if (pick < 68) begin
        drive_frame(8'($urandom), 1'b1, per, $urandom_range(0, per), 0,
                    $urandom_range(0, FRAME_BITS - 2));
        drive_level(1'b1, $urandom_range(0, 3 * per), 0);
      end else if (pick < 80) begin
        drive_level(1'b1, $urandom_range(1, 4), 1000);
        drive_noise(12 * per, per);
      end else if (pick < 90) begin
        drive_noise($urandom_range(1, 3 * per), per);
      end else begin
        drive_level(1'b1, $urandom_range(per, 6 * per), 0);
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_line_in   = 1'b1;
    in_send_req  = 1'b0;
    in_send_byte = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Register defaults, ending with a send that is still in its lead-in
    // when the period is shortened.
    drive_level(1'b1, 20, 0);
    drive_noise(20, 5);
    drive_level(1'b1, 2, 1000);
    wait_drained();

    set_config(16'd16, 16'd1);
    drive_level(1'b1, 20, 0);
    drive_frame(8'h00, 1'b1, 16, 4, 0, FRAME_BITS - 1);
    drive_frame(8'hA5, 1'b0, 16, 4, 0, FRAME_BITS - 1);
    drive_level(1'b1, 12, 0);
    // A send together with a start edge, then a second request while busy.
    drive_sample(1'b0, 1'b1, 8'h5A);
    drive_sample(1'b1, 1'b1, 8'h00);
    drive_noise(12 * 16, 16);
    drive_level(1'b1, 8, 0);
    // The period changes in the middle of a received frame.
    drive_frame(8'h3C, 1'b1, 16, 4, 0, 3);
    wait_drained();
    write_reg(CFG_BIT_PERIOD, 16'd24);
    drive_frame(8'h3C, 1'b1, 24, 0, 4, FRAME_BITS - 1);
    wait_drained();
    // Writes to unused indexes must leave both registers alone.
    write_reg(CFG_SPARE_2, 16'hFFFF);
    write_reg(CFG_SPARE_3, 16'($urandom));
    write_reg(CFG_BIT_PERIOD, 16'd16);
    drive_frame(8'hC3, 1'b1, 16, 4, 0, FRAME_BITS - 1);
    wait_drained();

    set_config(16'($urandom_range(4, 8)), 16'($urandom_range(2, 8)));
    run_random(80, 0);
    wait_drained();

    // Largest settings: the receiver sits in its half-bit wait far longer
    // than this phase lasts, so the requests here are refused.
    set_config(16'hFFFF, 16'hFFFF);
    drive_level(1'b1, 20, 0);
    drive_level(1'b0, 3, 0);
    drive_level(1'b1, 20, 1000);
    drive_noise(20, 8);
    wait_drained();

    // Zero period and zero timeout behave as one; small periods as given.
    set_config(16'd0, 16'd0);
    run_random(40, 0);
    wait_drained();
    set_config(16'd3, 16'd2);
    run_random(40, 0);
    wait_drained();

    set_config(16'($urandom_range(6, 12)), 16'($urandom_range(10, 40)));
    run_random(80, 0);

    idle_cycles(1);
    repeat (2000) begin
      if (sb.pending_results.size() == 0) break;
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (sb.pending_results.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending_results.size()));
    if (sb.errors == 0) begin
      $display("tb_single_wire_uart_transceiver_top: PASS");
    end else begin
      $display("tb_single_wire_uart_transceiver_top: FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_single_wire_uart_transceiver_top: FAIL");
    $finish;
  end

endmodule
